// ===== rtl/umds_pkg.sv =====
// Shared sizes, codes, payload structs and the entry-chain types for the UDS
// multi-DID response splitter. No dependencies.
package umds_pkg;

  localparam int MAX_ENTRIES        = 16;
  localparam int MAX_RESPONSE_BYTES = 256;

  localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W   = $clog2(MAX_RESPONSE_BYTES + 1);
  localparam int WCT_W   = $clog2(MAX_RESPONSE_BYTES + 2);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [7:0] RSP_POS = 8'h62;
  localparam logic [7:0] RSP_NEG = 8'h7F;

  // Negative response codes that count as not supported.
  localparam logic [7:0] NRC_SERVICE_NOT_SUPPORTED  = 8'h11;
  localparam logic [7:0] NRC_SUBFN_NOT_SUPPORTED    = 8'h12;
  localparam logic [7:0] NRC_OUT_OF_RANGE           = 8'h31;
  localparam logic [7:0] NRC_SUBFN_NOT_IN_SESSION   = 8'h7E;
  localparam logic [7:0] NRC_SERVICE_NOT_IN_SESSION = 8'h7F;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PROTO   = 3'd1;
  localparam logic [2:0] ST_NOTSUP  = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;

  localparam logic [2:0] PH_FIRST    = 3'd0;
  localparam logic [2:0] PH_NEG_SID  = 3'd1;
  localparam logic [2:0] PH_NEG_NRC  = 3'd2;
  localparam logic [2:0] PH_NEG_TAIL = 3'd3;
  localparam logic [2:0] PH_REC_HI   = 3'd4;
  localparam logic [2:0] PH_REC_LO   = 3'd5;
  localparam logic [2:0] PH_REC_DATA = 3'd6;
  localparam logic [2:0] PH_BAD      = 3'd7;

  typedef struct packed {
    logic        opcode;
    logic [15:0] entry_did;
    logic [7:0]  entry_length;
    logic [7:0]  resp_byte;
    logic        resp_last;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] entry_index;
    logic [7:0] data_byte;
    logic       record_end;
    logic [2:0] status;
    logic [7:0] neg_code;
    logic       last;
  } out_item_t;

  // Identifier query travelling down the entry chain.
  typedef struct packed {
    logic               active;
    logic               found;
    logic [15:0]        did;
    logic [ENTRY_W-1:0] idx;
    logic [7:0]         len;
  } query_t;

  // Broadcast write data for the entry chain; each cell has its own enable.
  typedef struct packed {
    logic [15:0] did;
    logic [7:0]  len;
  } load_t;

  // Window of entries that a query may match.
  typedef struct packed {
    logic [CNT_W-1:0] next_unmatched;
    logic [CNT_W-1:0] entry_total;
  } scope_t;

endpackage

// ===== rtl/umds_cell.sv =====
// One cell of the entry chain: holds one requested identifier and length and
// passes the registered query to its neighbor. Depends on umds_pkg.
module umds_cell import umds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [ENTRY_W-1:0] idx,
  input  logic               load_en,
  input  load_t              load,
  input  scope_t             scope,
  input  query_t             q_in,
  output query_t             q_out
);

  logic [15:0] did;
  logic [7:0]  len;
  logic        eligible;
  query_t      q_next;

  assign eligible = (CNT_W'(idx) >= scope.next_unmatched) &&
                    (CNT_W'(idx) < scope.entry_total);

  always_comb begin
    q_next = q_in;
    if (q_in.active && !q_in.found && eligible && (did == q_in.did)) begin
      q_next.found = 1'b1;
      q_next.idx   = idx;
      q_next.len   = len;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      did <= load.did;
      len <= load.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out <= '0;
    end else begin
      q_out <= q_next;
    end
  end

endmodule

// ===== rtl/uds_multi_did_response_splitter_unit.sv =====
// Top level of the UDS ReadDataByIdentifier response splitter: byte parser,
// final status and the chain of entry cells. Depends on umds_pkg, umds_cell.
//
//   channel   signals                 direction  transfer
//   item      start, busy, item       in         start high and busy low
//   result    strobe, result          out        every cycle strobe is high
//
// Loads and other response bytes leave busy low. The low identifier byte sends
// a query through the MAX_ENTRIES cells of the entry chain and holds busy
// until the query comes out of the last cell. The final byte holds busy
// while the status result goes out. Reset is synchronous and clears the
// parser; the entry table is not cleared. The receiver cannot stall, so
// each result is shown for exactly one cycle.
module uds_multi_did_response_splitter_unit import umds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      strobe,
  output out_item_t result
);

  localparam int SUM_W = ((WCT_W > 9) ? WCT_W : 9) + 1;
  localparam logic [SUM_W-1:0] WCT_SAT   = SUM_W'(MAX_RESPONSE_BYTES + 1);
  localparam logic [WCT_W-1:0] WCT_LIMIT = WCT_W'(MAX_RESPONSE_BYTES);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_RESPONSE_BYTES);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_ENTRIES);

  logic [CNT_W-1:0]   entry_total, entry_total_next;
  logic [CNT_W-1:0]   next_unmatched, next_unmatched_next;
  logic [ENTRY_W-1:0] current_entry, current_entry_next;
  logic [7:0]         bytes_left, bytes_left_next;
  logic [2:0]         parse_phase, parse_phase_next;
  logic [7:0]         id_high_byte, id_high_byte_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [WCT_W-1:0]   worst_case_total, worst_case_total_next;
  logic [2:0]         sticky_status, sticky_status_next;
  logic [7:0]         held_code, held_code_next;
  logic               searching, searching_next;
  logic               fin_pending, fin_pending_next;
  logic               strobe_next;
  out_item_t          result_next;

  logic                   accept;
  logic                   emit_ok;
  logic [SUM_W-1:0]       wct_sum;
  logic [2:0]             fin_status;
  logic [7:0]             fin_code;
  load_t                  load;
  scope_t                 scope;
  logic [MAX_ENTRIES-1:0] load_sel;
  query_t                 chain_head;
  query_t                 chain [MAX_ENTRIES+1];

  assign busy   = searching | fin_pending;
  assign accept = start & ~busy;
  assign emit_ok = (sticky_status == ST_OK) && (entry_total != '0);
  assign load.did = item.entry_did;
  assign load.len = item.entry_length;
  assign scope.next_unmatched = next_unmatched;
  assign scope.entry_total    = entry_total;
  assign wct_sum = SUM_W'(worst_case_total) + SUM_W'(item.entry_length) + SUM_W'(2);
  assign chain[0] = chain_head;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    umds_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (ENTRY_W'(g)),
      .load_en (load_sel[g]),
      .load    (load),
      .scope   (scope),
      .q_in    (chain[g]),
      .q_out   (chain[g+1])
    );
  end

  // Final status from the state that the last byte left behind.
  always_comb begin
    fin_code = 8'd0;
    if (sticky_status != ST_OK) begin
      fin_status = sticky_status;
    end else if (entry_total == '0) begin
      fin_status = ST_INVALID;
    end else if (parse_phase == PH_NEG_TAIL) begin
      fin_code = held_code;
      if (held_code inside {NRC_SERVICE_NOT_SUPPORTED, NRC_SUBFN_NOT_SUPPORTED,
                            NRC_OUT_OF_RANGE, NRC_SUBFN_NOT_IN_SESSION,
                            NRC_SERVICE_NOT_IN_SESSION}) begin
        fin_status = ST_NOTSUP;
      end else begin
        fin_status = ST_PROTO;
      end
    end else if (parse_phase == PH_REC_HI) begin
      fin_status = ST_OK;
    end else begin
      fin_status = ST_PROTO;
    end
  end

  always_comb begin
    entry_total_next      = entry_total;
    next_unmatched_next   = next_unmatched;
    current_entry_next    = current_entry;
    bytes_left_next       = bytes_left;
    parse_phase_next      = parse_phase;
    id_high_byte_next     = id_high_byte;
    byte_position_next    = byte_position;
    worst_case_total_next = worst_case_total;
    sticky_status_next    = sticky_status;
    held_code_next        = held_code;
    searching_next        = searching;
    fin_pending_next      = fin_pending;
    strobe_next           = 1'b0;
    result_next           = '0;
    load_sel              = '0;
    chain_head            = '0;

    if (accept && item.opcode == OP_LOAD) begin
      // Loads are ignored once a response has started.
      if (byte_position == '0) begin
        if (item.entry_length == 8'd0 || entry_total >= CNT_FULL) begin
          sticky_status_next = ST_INVALID;
        end else begin
          load_sel[entry_total[ENTRY_W-1:0]] = 1'b1;
          entry_total_next = entry_total + CNT_W'(1);
          if (wct_sum > WCT_SAT) begin
            worst_case_total_next = WCT_W'(WCT_SAT);
          end else begin
            worst_case_total_next = WCT_W'(wct_sum);
          end
          if (worst_case_total_next > WCT_LIMIT && sticky_status != ST_INVALID) begin
            sticky_status_next = ST_OVERRUN;
          end
        end
      end
    end

    if (accept && item.opcode == OP_BYTE) begin
      if (byte_position >= POS_LIMIT) begin
        if (sticky_status != ST_INVALID) begin
          sticky_status_next = ST_OVERRUN;
        end
      end else begin
        byte_position_next = byte_position + POS_W'(1);
        case (parse_phase)
          PH_FIRST: begin
            if (item.resp_byte == RSP_NEG) begin
              parse_phase_next = PH_NEG_SID;
            end else if (item.resp_byte == RSP_POS) begin
              parse_phase_next = PH_REC_HI;
            end else begin
              parse_phase_next = PH_BAD;
            end
          end
          PH_NEG_SID: parse_phase_next = PH_NEG_NRC;
          PH_NEG_NRC: begin
            held_code_next   = item.resp_byte;
            parse_phase_next = PH_NEG_TAIL;
          end
          PH_REC_HI: begin
            id_high_byte_next = item.resp_byte;
            parse_phase_next  = PH_REC_LO;
          end
          PH_REC_LO: begin
            chain_head.active = 1'b1;
            chain_head.did    = {id_high_byte, item.resp_byte};
            searching_next    = 1'b1;
          end
          PH_REC_DATA: begin
            if (emit_ok) begin
              strobe_next             = 1'b1;
              result_next.kind        = 1'b0;
              result_next.entry_index = 4'(current_entry);
              result_next.data_byte   = item.resp_byte;
              result_next.record_end  = (bytes_left == 8'd1);
              result_next.last        = ~item.resp_last;
            end
            if (bytes_left != 8'd0) begin
              bytes_left_next = bytes_left - 8'd1;
            end
            if (bytes_left_next == 8'd0) begin
              parse_phase_next = PH_REC_HI;
            end
          end
          default: ;
        endcase
      end
      if (item.resp_last) begin
        fin_pending_next = 1'b1;
      end
    end

    // The query comes out of the last cell with the first eligible match.
    if (searching && chain[MAX_ENTRIES].active) begin
      searching_next = 1'b0;
      if (chain[MAX_ENTRIES].found) begin
        current_entry_next  = chain[MAX_ENTRIES].idx;
        next_unmatched_next = CNT_W'(chain[MAX_ENTRIES].idx) + CNT_W'(1);
        bytes_left_next     = chain[MAX_ENTRIES].len;
        if (chain[MAX_ENTRIES].len != 8'd0) begin
          parse_phase_next = PH_REC_DATA;
        end else begin
          parse_phase_next = PH_REC_HI;
        end
      end else begin
        parse_phase_next = PH_BAD;
      end
    end

    if (fin_pending && !searching) begin
      strobe_next           = 1'b1;
      result_next.kind      = 1'b1;
      result_next.status    = fin_status;
      result_next.neg_code  = fin_code;
      result_next.last      = 1'b1;
      fin_pending_next      = 1'b0;
      entry_total_next      = '0;
      next_unmatched_next   = '0;
      current_entry_next    = '0;
      bytes_left_next       = 8'd0;
      parse_phase_next      = PH_FIRST;
      id_high_byte_next     = 8'd0;
      byte_position_next    = '0;
      worst_case_total_next = WCT_W'(1);
      sticky_status_next    = ST_OK;
      held_code_next        = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_total      <= '0;
      next_unmatched   <= '0;
      current_entry    <= '0;
      bytes_left       <= 8'd0;
      parse_phase      <= PH_FIRST;
      id_high_byte     <= 8'd0;
      byte_position    <= '0;
      worst_case_total <= WCT_W'(1);
      sticky_status    <= ST_OK;
      held_code        <= 8'd0;
      searching        <= 1'b0;
      fin_pending      <= 1'b0;
      strobe           <= 1'b0;
    end else begin
      entry_total      <= entry_total_next;
      next_unmatched   <= next_unmatched_next;
      current_entry    <= current_entry_next;
      bytes_left       <= bytes_left_next;
      parse_phase      <= parse_phase_next;
      id_high_byte     <= id_high_byte_next;
      byte_position    <= byte_position_next;
      worst_case_total <= worst_case_total_next;
      sticky_status    <= sticky_status_next;
      held_code        <= held_code_next;
      searching        <= searching_next;
      fin_pending      <= fin_pending_next;
      strobe           <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // No result goes out while a query walks the chain.
  a_quiet_search: assert property (@(posedge clk) disable iff (rst)
    searching |-> !strobe)
    else $error("result transfer during identifier search");

  // A query leaves the chain only while the parser waits for it.
  a_tail_owned: assert property (@(posedge clk) disable iff (rst)
    chain[MAX_ENTRIES].active |-> searching)
    else $error("query left the chain with no search pending");

  // A pending final status goes out in the next cycle once the search is over.
  a_status_out: assert property (@(posedge clk) disable iff (rst)
    (fin_pending && !searching) |=> (strobe && result.kind && result.last))
    else $error("final status transfer missing");

  // Data bytes belong to a loaded entry.
  a_data_entry: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.kind) |-> (CNT_W'(result.entry_index) < entry_total))
    else $error("data byte tagged with an entry that was not loaded");

endmodule

// ===== dv/tb_uds_multi_did_response_splitter_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the UDS multi-DID response splitter: directed
// table, then random load/response transactions checked against a predictor.
// Depends on umds_pkg and uds_multi_did_response_splitter_unit.
module tb_uds_multi_did_response_splitter_unit import umds_pkg::*; ;

  localparam logic [7:0] SID_RDBI = 8'h22;

  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 8;

  typedef struct {
    in_item_t   it;
    bit         pinned;
    logic [2:0] st;
    logic [7:0] nc;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      strobe;
  out_item_t result;

  uds_multi_did_response_splitter_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  // Predictor state of the parser and the entry table.
  logic [15:0]  req_did [MAX_ENTRIES];
  logic [7:0]   req_len [MAX_ENTRIES];
  int           n_loaded;
  int           next_free;
  int           cur_entry;
  int           bytes_left;
  logic [2:0]   phase;
  logic [7:0]   did_hi;
  int           resp_pos;
  int           worst_len;
  logic [2:0]   sticky;
  logic [7:0]   held_nrc;

  out_item_t step_out[$];
  out_item_t expected_out[$];
  dir_row_t  dir_rows[$];
  out_item_t want;
  int        mismatches;
  int        burst_left;
  int        sent_items;
  int        waited;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_uds_multi_did_response_splitter_unit: errors");
    $finish;
  end

  function automatic void clear_txn();
    n_loaded   = 0;
    next_free  = 0;
    cur_entry  = 0;
    bytes_left = 0;
    phase      = PH_FIRST;
    did_hi     = 8'h00;
    resp_pos   = 0;
    worst_len  = 1;
    sticky     = ST_OK;
    held_nrc   = 8'h00;
  endfunction

  function automatic bit nrc_unsupported(logic [7:0] c);
    return c == NRC_SERVICE_NOT_SUPPORTED || c == NRC_SUBFN_NOT_SUPPORTED ||
           c == NRC_OUT_OF_RANGE || c == NRC_SUBFN_NOT_IN_SESSION ||
           c == NRC_SERVICE_NOT_IN_SESSION;
  endfunction

  // Works out the results of one accepted item into step_out.
  function automatic void parse_item(in_item_t x);
    logic        emit_ok;
    logic [15:0] did;
    logic [2:0]  st;
    logic [7:0]  nc;
    int          i;
    step_out.delete();
    if (x.opcode == OP_LOAD) begin
      if (resp_pos != 0) return;
      if (x.entry_length == 8'd0 || n_loaded >= MAX_ENTRIES) begin
        sticky = ST_INVALID;
        return;
      end
      req_did[n_loaded] = x.entry_did;
      req_len[n_loaded] = x.entry_length;
      n_loaded++;
      worst_len += 2 + int'(x.entry_length);
      if (worst_len > MAX_RESPONSE_BYTES + 1) worst_len = MAX_RESPONSE_BYTES + 1;
      if (worst_len > MAX_RESPONSE_BYTES && sticky != ST_INVALID) sticky = ST_OVERRUN;
      return;
    end
    if (resp_pos >= MAX_RESPONSE_BYTES) begin
      if (sticky != ST_INVALID) sticky = ST_OVERRUN;
    end else begin
      emit_ok = (sticky == ST_OK) && (n_loaded != 0);
      resp_pos++;
      case (phase)
        PH_FIRST: begin
          if (x.resp_byte == RSP_NEG) phase = PH_NEG_SID;
          else if (x.resp_byte == RSP_POS) phase = PH_REC_HI;
          else phase = PH_BAD;
        end
        PH_NEG_SID: phase = PH_NEG_NRC;
        PH_NEG_NRC: begin
          held_nrc = x.resp_byte;
          phase = PH_NEG_TAIL;
        end
        PH_REC_HI: begin
          did_hi = x.resp_byte;
          phase = PH_REC_LO;
        end
        PH_REC_LO: begin
          // Forward search from the first entry not yet matched.
          did = {did_hi, x.resp_byte};
          i = next_free;
          while (i < n_loaded && req_did[i] != did) i++;
          if (i >= n_loaded) begin
            phase = PH_BAD;
          end else begin
            cur_entry  = i;
            next_free  = i + 1;
            bytes_left = req_len[i];
            phase = (bytes_left != 0) ? PH_REC_DATA : PH_REC_HI;
          end
        end
        PH_REC_DATA: begin
          if (emit_ok) begin
            step_out.push_back('{kind: 1'b0, entry_index: cur_entry[3:0],
                                 data_byte: x.resp_byte, record_end: bytes_left == 1,
                                 status: ST_OK, neg_code: 8'h00,
                                 last: !x.resp_last});
          end
          if (bytes_left > 0) bytes_left--;
          if (bytes_left == 0) phase = PH_REC_HI;
        end
        default: ;
      endcase
    end
    if (x.resp_last) begin
      nc = 8'h00;
      if (sticky != ST_OK) st = sticky;
      else if (n_loaded == 0) st = ST_INVALID;
      else if (phase == PH_NEG_TAIL) begin
        nc = held_nrc;
        st = nrc_unsupported(held_nrc) ? ST_NOTSUP : ST_PROTO;
      end else if (phase == PH_REC_HI) st = ST_OK;
      else st = ST_PROTO;
      step_out.push_back('{kind: 1'b1, entry_index: 4'd0, data_byte: 8'h00,
                           record_end: 1'b0, status: st, neg_code: nc, last: 1'b1});
      clear_txn();
    end
  endfunction

  function automatic in_item_t load_item(logic [15:0] did, logic [7:0] len);
    in_item_t x;
    x.opcode       = OP_LOAD;
    x.entry_did    = did;
    x.entry_length = len;
    x.resp_byte    = 8'($urandom);
    x.resp_last    = 1'($urandom);
    return x;
  endfunction

  function automatic in_item_t byte_item(logic [7:0] b, logic fin);
    in_item_t x;
    x.opcode       = OP_BYTE;
    x.entry_did    = 16'($urandom);
    x.entry_length = 8'($urandom);
    x.resp_byte    = b;
    x.resp_last    = fin;
    return x;
  endfunction

  task automatic add_row(in_item_t it, bit pinned = 1'b0, logic [2:0] st = ST_OK,
                         logic [7:0] nc = 8'h00);
    dir_rows.push_back('{it: it, pinned: pinned, st: st, nc: nc});
  endtask

  // Sends one item in bursts with random gaps; a pinned row queues the typed
  // status instead of the predicted one, while the predictor still advances.
  task automatic send(in_item_t x, bit pinned = 1'b0, logic [2:0] st = ST_OK,
                      logic [7:0] nc = 8'h00);
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    start <= 1'b1;
    item  <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    parse_item(x);
    if (pinned) begin
      expected_out.push_back('{kind: 1'b1, entry_index: 4'd0, data_byte: 8'h00,
                               record_end: 1'b0, status: st, neg_code: nc, last: 1'b1});
    end else begin
      foreach (step_out[k]) expected_out.push_back(step_out[k]);
    end
  endtask

  task automatic random_transaction();
    logic [15:0] dids[$];
    logic [7:0]  lens[$];
    logic [7:0]  resp[$];
    logic [15:0] did;
    logic [7:0]  len;
    int          n_ent;
    int          shape;
    int          n_cut;
    if ($urandom_range(0, 9) == 0) n_ent = 0;
    else if ($urandom_range(0, 14) == 0) n_ent = $urandom_range(MAX_ENTRIES - 1,
                                                                MAX_ENTRIES + 2);
    else n_ent = $urandom_range(1, 5);
    for (int e = 0; e < n_ent; e++) begin
      // A small pool of identifiers makes repeated DIDs likely.
      did = ($urandom_range(0, 2) == 0) ? 16'h0F00 + 16'($urandom_range(0, 3))
                                        : 16'($urandom);
      if ($urandom_range(0, 29) == 0) len = 8'd0;
      else if ($urandom_range(0, 11) == 0) len = 8'($urandom_range(7, 255));
      else len = 8'($urandom_range(1, 6));
      send(load_item(did, len));
      sent_items++;
      if (len != 0 && dids.size() < MAX_ENTRIES) begin
        dids.push_back(did);
        lens.push_back(len);
      end
    end
    shape = $urandom_range(0, 99);
    if (shape < 70) begin
      resp.push_back(RSP_POS);
      foreach (dids[j]) begin
        if ($urandom_range(0, 3) != 0) begin
          resp.push_back(dids[j][15:8]);
          resp.push_back(dids[j][7:0]);
          for (int d = 0; d < lens[j]; d++) resp.push_back(8'($urandom));
        end
      end
      case ($urandom_range(0, 9))
        0: begin
          n_cut = $urandom_range(0, resp.size() - 1);
          repeat (n_cut) void'(resp.pop_back());
        end
        1: repeat ($urandom_range(1, 2)) resp.push_back(8'($urandom));
        2: repeat ($urandom_range(2, 5)) resp.push_back(8'($urandom));
        default: ;
      endcase
    end else if (shape < 85) begin
      resp.push_back(RSP_NEG);
      resp.push_back(SID_RDBI);
      case ($urandom_range(0, 6))
        0: resp.push_back(NRC_SERVICE_NOT_SUPPORTED);
        1: resp.push_back(NRC_SUBFN_NOT_SUPPORTED);
        2: resp.push_back(NRC_OUT_OF_RANGE);
        3: resp.push_back(NRC_SUBFN_NOT_IN_SESSION);
        4: resp.push_back(NRC_SERVICE_NOT_IN_SESSION);
        default: resp.push_back(8'($urandom));
      endcase
      repeat ($urandom_range(0, 2)) resp.push_back(8'($urandom));
      if ($urandom_range(0, 5) == 0) begin
        n_cut = $urandom_range(1, 2);
        while (resp.size() > n_cut) void'(resp.pop_back());
      end
    end else if (shape < 97) begin
      repeat ($urandom_range(1, 8)) resp.push_back(8'($urandom));
    end else begin
      resp.push_back(RSP_POS);
      repeat ($urandom_range(MAX_RESPONSE_BYTES, MAX_RESPONSE_BYTES + 40))
        resp.push_back(8'($urandom));
    end
    foreach (resp[p]) begin
      // A load in the middle of a response is ignored by the block.
      if (p > 0 && $urandom_range(0, 19) == 0) send(load_item(16'($urandom), 8'($urandom)));
      send(byte_item(resp[p], p == resp.size() - 1));
      sent_items++;
    end
  endtask

  task automatic field_check(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Every strobed result is a transfer; compare it with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %p", $time, result);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        field_check("kind", 16'(want.kind), 16'(result.kind));
        field_check("entry_index", 16'(want.entry_index), 16'(result.entry_index));
        field_check("data_byte", 16'(want.data_byte), 16'(result.data_byte));
        field_check("record_end", 16'(want.record_end), 16'(result.record_end));
        field_check("status", 16'(want.status), 16'(result.status));
        field_check("neg_code", 16'(want.neg_code), 16'(result.neg_code));
        field_check("last", 16'(want.last), 16'(result.last));
      end
    end
  end

  initial begin
    mismatches = 0;
    burst_left = 0;
    sent_items = 0;
    clear_txn();
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;

    // Response with nothing loaded, then a zero length load.
    add_row(byte_item(RSP_POS, 1'b1), 1'b1, ST_INVALID);
    add_row(load_item(16'h0000, 8'd0));
    add_row(byte_item(8'h55, 1'b1), 1'b1, ST_INVALID);
    // Two records, the first at identifier FFFF, with a load mid-response.
    add_row(load_item(16'hFFFF, 8'd1));
    add_row(load_item(16'h1234, 8'd2));
    add_row(byte_item(RSP_POS, 1'b0));
    add_row(byte_item(8'hFF, 1'b0));
    add_row(byte_item(8'hFF, 1'b0));
    add_row(byte_item(8'hAB, 1'b0));
    add_row(load_item(16'h0000, 8'd5));
    add_row(byte_item(8'h12, 1'b0));
    add_row(byte_item(8'h34, 1'b0));
    add_row(byte_item(8'h00, 1'b0));
    add_row(byte_item(8'hFF, 1'b1));
    // Worst case total too large.
    add_row(load_item(16'hABCD, 8'd255));
    add_row(load_item(16'h5555, 8'd255));
    add_row(byte_item(RSP_NEG, 1'b1), 1'b1, ST_OVERRUN);
    // Negative response in the not-supported family.
    add_row(load_item(16'h0102, 8'd1));
    add_row(byte_item(RSP_NEG, 1'b0));
    add_row(byte_item(SID_RDBI, 1'b0));
    add_row(byte_item(NRC_SERVICE_NOT_SUPPORTED, 1'b1), 1'b1, ST_NOTSUP,
            NRC_SERVICE_NOT_SUPPORTED);
    // Short negative response.
    add_row(load_item(16'h0102, 8'd1));
    add_row(byte_item(RSP_NEG, 1'b0));
    add_row(byte_item(SID_RDBI, 1'b1), 1'b1, ST_PROTO);
    // Unrecognized first byte.
    add_row(load_item(16'h0001, 8'd1));
    add_row(byte_item(8'h00, 1'b1), 1'b1, ST_PROTO);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) send(dir_rows[r].it, dir_rows[r].pinned, dir_rows[r].st,
                               dir_rows[r].nc);
    while (sent_items < RANDOM_ITEMS) random_transaction();
    start <= 1'b0;

    waited = 0;
    while (expected_out.size() != 0 && waited < 100_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_out.size() != 0) begin
      $display("%0t: %0d results never arrived, oldest expected %p", $time,
               expected_out.size(), expected_out[0]);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_uds_multi_did_response_splitter_unit: clean");
    end else begin
      $display("tb_uds_multi_did_response_splitter_unit: errors");
    end
    $finish;
  end

endmodule
